@@ hw/rtl/sjisgf_pkg.sv @@
// ----------------------------------------------------------------------------
// sjisgf_pkg
// Shared types, constants and character-class functions for the Shift-JIS
// gaiji filter.
// ----------------------------------------------------------------------------
package sjisgf_pkg;

    localparam logic [15:0] SJISGF_REPL_RESET = 16'h8140;
    localparam int          SJISGF_Q_DEPTH    = 4;

    // one result beat
    typedef struct packed {
        logic [7:0] out_byte;
        logic       bad_char;
        logic       string_end;
        logic       run_last;
    } t_result;

    // what one input byte produces
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_dec;

    typedef struct packed {
        logic lead_pending;
        logic discarding;
    } t_dec_status;

    function automatic logic is_single(input logic [7:0] b);
        return (b >= 8'h01 && b <= 8'h7F) || (b >= 8'hA1 && b <= 8'hDF);
    endfunction

    function automatic logic is_lead(input logic [7:0] b);
        return (b >= 8'h81 && b <= 8'h9F) || (b >= 8'hE0 && b <= 8'hFC);
    endfunction

    function automatic logic is_trail(input logic [7:0] b);
        return (b >= 8'h40 && b <= 8'h7E) || (b >= 8'h80 && b <= 8'hFC);
    endfunction

    // vendor and user-defined character ranges
    function automatic logic is_gaiji(input logic [7:0] lead, input logic [7:0] trail);
        logic g;
        g = 1'b0;
        if (lead == 8'h84) begin
            g = (trail >= 8'h92);
        end else if (lead >= 8'h85 && lead <= 8'h86) begin
            g = 1'b1;
        end else if (lead == 8'h87) begin
            g = (trail >= 8'h9D);
        end else if (lead == 8'h88) begin
            g = (trail <= 8'h9E);
        end else if (lead == 8'hEA) begin
            g = (trail >= 8'hA5);
        end else if (lead >= 8'hEB && lead <= 8'hEC) begin
            g = 1'b1;
        end else if (lead == 8'hEE) begin
            g = (trail >= 8'hFD);
        end else if (lead >= 8'hEF && lead <= 8'hFA) begin
            g = 1'b1;
        end else if (lead == 8'hFC) begin
            g = (trail >= 8'h4B);
        end
        return g;
    endfunction

endpackage

@@ hw/rtl/sjisgf_if.sv @@
// ----------------------------------------------------------------------------
// sjisgf_if
// Valid/ready channels of the Shift-JIS gaiji filter: input bytes, result
// beats and the replacement code write port.
// ----------------------------------------------------------------------------
interface sjisgf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       final_byte;

    modport source (output valid, output in_byte, output final_byte, input ready);
    modport sink   (input valid, input in_byte, input final_byte, output ready);
endinterface

interface sjisgf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       bad_char;
    logic       string_end;
    logic       run_last;

    modport source (output valid, output out_byte, output bad_char, output string_end,
                    output run_last, input ready);
    modport sink   (input valid, input out_byte, input bad_char, input string_end,
                    input run_last, output ready);
endinterface

interface sjisgf_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] replacement_code;

    modport source (output valid, output replacement_code, input ready);
    modport sink   (input valid, input replacement_code, output ready);
endinterface

@@ hw/rtl/sjis_gaiji_filter.sv @@
// ----------------------------------------------------------------------------
// sjis_gaiji_filter
// Shift-JIS byte filter with gaiji replacement: input register, decoder and
// a small result queue that drains one beat per cycle when o_out is ready.
// ----------------------------------------------------------------------------
// An accepted byte passes through the input register and the decoder into the
//   result queue, from which its beats are offered.
// Throughput: one input byte per cycle, one result beat per cycle while o_out
//   is ready; two bytes of a character give two beats, so the queue keeps pace.
// Input stalls only while the result queue holds more than Q_DEPTH-2 beats.
// Reset (synchronous, active low) empties the input stage and the queue,
// clears decoder state and sets the replacement code to 0x8140.
module sjis_gaiji_filter
    import sjisgf_pkg::*;
#(
    parameter int Q_DEPTH = SJISGF_Q_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    sjisgf_in_if.sink     i_in,
    sjisgf_out_if.source  o_out,
    sjisgf_cfg_if.sink    i_cfg
);

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    // configuration
    logic [15:0] r_repl;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repl <= SJISGF_REPL_RESET;
        end else if (i_cfg.valid) begin
            r_repl <= i_cfg.replacement_code;
        end
    end

    // input register
    logic        r_s1_valid;
    logic [7:0]  r_s1_byte;
    logic        r_s1_final;
    logic        s1_adv;
    logic        in_fire;
    logic [CW-1:0] r_count;

    assign s1_adv     = r_s1_valid && (r_count <= CW'(Q_DEPTH - 2));
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign in_fire    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_byte  <= i_in.in_byte;
            r_s1_final <= i_in.final_byte;
        end
    end

    // decode
    t_dec        dec;
    t_dec_status dec_st;

    sjisgf_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (s1_adv),
        .i_byte   (r_s1_byte),
        .i_final  (r_s1_final),
        .i_repl   (r_repl),
        .o_dec    (dec),
        .o_status (dec_st)
    );

    // result queue
    t_result       r_q [Q_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [PW-1:0] wr1;
    logic [PW-1:0] wr2;
    logic [PW-1:0] rd1;
    logic [1:0]    push_n;
    logic          pop;
    logic [PW-1:0] n_wr;
    logic [PW-1:0] n_rd;
    logic [CW-1:0] n_count;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(Q_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign push_n = s1_adv ? dec.count : 2'd0;
    assign pop    = o_out.valid && o_out.ready;
    assign wr1    = ptr_inc(r_wr);
    assign wr2    = ptr_inc(wr1);
    assign rd1    = ptr_inc(r_rd);

    always_comb begin
        case (push_n)
            2'd1:    n_wr = wr1;
            2'd2:    n_wr = wr2;
            default: n_wr = r_wr;
        endcase
        n_rd    = pop ? rd1 : r_rd;
        n_count = r_count + CW'(push_n) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_q[r_wr] <= dec.res0;
        end
        if (push_n == 2'd2) begin
            r_q[wr1] <= dec.res1;
        end
    end

    assign o_out.valid      = (r_count != '0);
    assign o_out.out_byte   = r_q[r_rd].out_byte;
    assign o_out.bad_char   = r_q[r_rd].bad_char;
    assign o_out.string_end = r_q[r_rd].string_end;
    assign o_out.run_last   = r_q[r_rd].run_last;

`ifndef SYNTHESIS
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(Q_DEPTH))
        else $error("result queue overflow");

    a_state_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(dec_st.lead_pending && dec_st.discarding))
        else $error("lead held while dropping string");

    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.bad_char) |-> (o_out.run_last && o_out.out_byte == 8'h00))
        else $error("error beat malformed");

    a_drop_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && dec_st.discarding && !r_s1_final) |=> (r_count <= $past(r_count)))
        else $error("dropped byte produced a result");
`endif

endmodule

@@ hw/rtl/sjisgf_decode.sv @@
// ----------------------------------------------------------------------------
// sjisgf_decode
// Character decoder: holds the lead byte and drop state, and turns each byte
// into zero, one or two result beats.
// ----------------------------------------------------------------------------
module sjisgf_decode
    import sjisgf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_adv,
    input  logic [7:0]  i_byte,
    input  logic        i_final,
    input  logic [15:0] i_repl,
    output t_dec        o_dec,
    output t_dec_status o_status
);

    logic [7:0] r_held_lead;
    logic       r_lead_pending;
    logic       r_discarding;
    logic [7:0] n_held_lead;
    logic       n_lead_pending;
    logic       n_discarding;

    always_comb begin
        t_dec d;
        d              = '0;
        n_held_lead    = r_held_lead;
        n_lead_pending = r_lead_pending;
        n_discarding   = r_discarding;
        if (r_discarding) begin
            // drop until the final byte, then close the string
            if (i_final) begin
                d.count      = 2'd1;
                d.res0       = '{out_byte: 8'h00, bad_char: 1'b1, string_end: 1'b1,
                                 run_last: 1'b1};
                n_discarding = 1'b0;
            end
        end else if (r_lead_pending && is_trail(i_byte)) begin
            d.count        = 2'd2;
            n_lead_pending = 1'b0;
            n_held_lead    = 8'h00;
            if (is_gaiji(r_held_lead, i_byte)) begin
                d.res0 = '{out_byte: i_repl[15:8], bad_char: 1'b0, string_end: 1'b0,
                           run_last: 1'b0};
                d.res1 = '{out_byte: i_repl[7:0], bad_char: 1'b0, string_end: i_final,
                           run_last: 1'b1};
            end else begin
                d.res0 = '{out_byte: r_held_lead, bad_char: 1'b0, string_end: 1'b0,
                           run_last: 1'b0};
                d.res1 = '{out_byte: i_byte, bad_char: 1'b0, string_end: i_final,
                           run_last: 1'b1};
            end
        end else if (!r_lead_pending && is_single(i_byte)) begin
            d.count = 2'd1;
            d.res0  = '{out_byte: i_byte, bad_char: 1'b0, string_end: i_final,
                        run_last: 1'b1};
        end else if (!r_lead_pending && is_lead(i_byte) && !i_final) begin
            n_held_lead    = i_byte;
            n_lead_pending = 1'b1;
        end else begin
            // bad byte, bad trail or lead at string end
            d.count        = 2'd1;
            d.res0         = '{out_byte: 8'h00, bad_char: 1'b1, string_end: i_final,
                               run_last: 1'b1};
            n_lead_pending = 1'b0;
            n_held_lead    = 8'h00;
            n_discarding   = !i_final;
        end
        o_dec = d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_lead    <= 8'h00;
            r_lead_pending <= 1'b0;
            r_discarding   <= 1'b0;
        end else if (i_adv) begin
            r_held_lead    <= n_held_lead;
            r_lead_pending <= n_lead_pending;
            r_discarding   <= n_discarding;
        end
    end

    assign o_status = '{lead_pending: r_lead_pending, discarding: r_discarding};

endmodule
